// ===== src/bss_pkg.sv =====
// Package for the bounded substring search block.
// Holds field widths, register addresses and the configuration struct.
// No dependencies.
package bss_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 8;
  localparam int unsigned TEXT_MAX_DEF    = 65536;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PAT_W     = 64;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned OFFSET_W  = 16;
  localparam int unsigned CMP_W     = 17;
  localparam int unsigned APB_DW    = 64;
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_LIMIT_ENABLE   = 2'd2,
    REG_SEARCH_LIMIT   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [PAT_W-1:0]   pattern_bytes;
    logic [LEN_W-1:0]   pattern_length;
    logic               limit_enable;
    logic [LIMIT_W-1:0] search_limit;
  } cfg_t;

endpackage

// ===== src/bss_if.sv =====
// Stream interfaces of the bounded substring search block.
// Depends on bss_pkg for the payload widths.
interface bss_in_if
  import bss_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              starts_text;
  logic              ends_text;

  modport source (output valid, text_byte, starts_text, ends_text, input ready);
  modport sink   (input valid, text_byte, starts_text, ends_text, output ready);
endinterface

interface bss_out_if
  import bss_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic                found;
  logic [OFFSET_W-1:0] match_offset;

  modport source (output valid, found, match_offset, input ready);
  modport sink   (input valid, found, match_offset, output ready);
endinterface

// ===== src/bounded_substring_search.sv =====
// Top level of the bounded substring search block.
// Depends on bss_pkg, bss_if, bss_cfg_regs and bss_search_core.
//
// Usage:
//   txt_i carries text bytes with starts_text and ends_text flags; res_o
//   carries one result per text: found and match_offset. Both channels
//   move an item when valid and ready are high at a rising edge.
//   The APB port holds pattern_bytes (0x00), pattern_length (0x08),
//   limit_enable (0x10) and search_limit (0x18); write it only while idle.
//   A text begins with a byte flagged starts_text; bytes before that, and
//   bytes after its result, are dropped. A result comes at the first match,
//   the zero terminator, the search limit, the text maximum or ends_text.
//   A byte is registered in the input register on acceptance; its result is
//   loaded into the output register when that is empty or being taken.
//   Throughput: one byte per cycle while the output register is free, set by
//   the combinational window compare between the input and result registers.
//   When the receiver stalls with a result held, one further byte waits in
//   the input register and then ready falls.
//   Reset empties both registers and closes the search; the block then waits
//   for a starting byte.
module bounded_substring_search
  import bss_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int unsigned TEXT_MAX    = TEXT_MAX_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  bss_in_if.sink            txt_i,
  bss_out_if.source         res_o
);

  cfg_t cfg;

  bss_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bss_search_core #(
    .PATTERN_MAX (PATTERN_MAX),
    .TEXT_MAX    (TEXT_MAX)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .txt_i  (txt_i),
    .res_o  (res_o)
  );

endmodule

// ===== src/bss_cfg_regs.sv =====
// APB-style configuration registers of the substring search.
// Depends on bss_pkg for the register map and cfg_t.
module bss_cfg_regs
  import bss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_AW-1:APB_AW-REG_IDX_W]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_PATTERN_BYTES:  cfg_d.pattern_bytes  = pwdata[PAT_W-1:0];
        REG_PATTERN_LENGTH: cfg_d.pattern_length = pwdata[LEN_W-1:0];
        REG_LIMIT_ENABLE:   cfg_d.limit_enable   = pwdata[0];
        REG_SEARCH_LIMIT:   cfg_d.search_limit   = pwdata[LIMIT_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PATTERN_BYTES:  prdata = APB_DW'(cfg_q.pattern_bytes);
      REG_PATTERN_LENGTH: prdata = APB_DW'(cfg_q.pattern_length);
      REG_LIMIT_ENABLE:   prdata = APB_DW'(cfg_q.limit_enable);
      REG_SEARCH_LIMIT:   prdata = APB_DW'(cfg_q.search_limit);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== src/bss_window_cmp.sv =====
// Parallel compare of the byte window against the configured pattern.
// Depends on bss_pkg for widths.
module bss_window_cmp
  import bss_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic [PATTERN_MAX*BYTE_W-1:0] window_i,
  input  logic [PAT_W-1:0]              pattern_i,
  input  logic [LEN_W-1:0]              len_i,
  output logic                          match_o
);

  logic [PATTERN_MAX:1] match_len;

  always_comb begin
    logic ok;
    for (int l = 1; l <= PATTERN_MAX; l++) begin
      ok = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (window_i[BYTE_W*(l-1-i) +: BYTE_W] != pattern_i[BYTE_W*i +: BYTE_W]) begin
          ok = 1'b0;
        end
      end
      match_len[l] = ok;
    end
  end

  always_comb begin
    match_o = 1'b0;
    for (int l = 1; l <= PATTERN_MAX; l++) begin
      if (len_i == LEN_W'(l)) begin
        match_o = match_len[l];
      end
    end
  end

endmodule

// ===== src/bss_search_core.sv =====
// Search datapath: input register, window and count state, result register.
// Depends on bss_pkg, bss_if and bss_window_cmp.
module bss_search_core
  import bss_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int unsigned TEXT_MAX    = TEXT_MAX_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  bss_in_if.sink        txt_i,
  bss_out_if.source     res_o
);

  localparam int unsigned WIN_W = PATTERN_MAX * BYTE_W;
  localparam int unsigned CNT_W = $clog2(TEXT_MAX + 1);

  logic                in_valid_q, in_valid_d;
  logic [BYTE_W-1:0]   byte_q;
  logic                starts_q, ends_q;
  logic [WIN_W-1:0]    win_q, win_d, win_s, win_n;
  logic [CNT_W-1:0]    cnt_q, cnt_d, cnt_s, cnt_n;
  logic                done_q, done_d, done_s;
  logic                out_valid_q, out_valid_d;
  logic                found_q;
  logic [OFFSET_W-1:0] offset_q;
  logic                emit, hit;
  logic [OFFSET_W-1:0] off;
  logic [LEN_W-1:0]    len_c;
  logic                win_match, accept, proc, out_free;

  assign len_c = (cfg_i.pattern_length > LEN_W'(PATTERN_MAX)) ?
                 LEN_W'(PATTERN_MAX) : cfg_i.pattern_length;

  assign out_free    = !out_valid_q || res_o.ready;
  assign proc        = in_valid_q && out_free;
  assign txt_i.ready = !in_valid_q || proc;
  assign accept      = txt_i.valid && txt_i.ready;

  assign win_s = starts_q ? '0 : win_q;
  assign cnt_s = starts_q ? '0 : cnt_q;
  assign done_s = starts_q ? 1'b0 : done_q;
  assign win_n = (win_s << BYTE_W) | WIN_W'(byte_q);
  assign cnt_n = cnt_s + CNT_W'(1);

  bss_window_cmp #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_cmp (
    .window_i  (win_n),
    .pattern_i (cfg_i.pattern_bytes),
    .len_i     (len_c),
    .match_o   (win_match)
  );

  always_comb begin
    win_d  = win_q;
    cnt_d  = cnt_q;
    done_d = done_q;
    emit   = 1'b0;
    hit    = 1'b0;
    off    = '0;
    if (proc) begin
      win_d  = win_s;
      cnt_d  = cnt_s;
      done_d = done_s;
      if (!done_s) begin
        if (len_c == '0) begin
          emit = 1'b1;
          hit  = 1'b1;
        end else if (byte_q == '0) begin
          emit = 1'b1;
        end else begin
          win_d = win_n;
          cnt_d = cnt_n;
          if ((cnt_n >= CNT_W'(len_c)) && win_match &&
              (!cfg_i.limit_enable || (CMP_W'(cnt_n) <= CMP_W'(cfg_i.search_limit)))) begin
            emit = 1'b1;
            hit  = 1'b1;
            off  = OFFSET_W'(cnt_n - CNT_W'(len_c));
          end else if (cfg_i.limit_enable &&
                       (CMP_W'(cnt_n) >= CMP_W'(cfg_i.search_limit))) begin
            emit = 1'b1;
          end else if (CMP_W'(cnt_n) >= CMP_W'(TEXT_MAX)) begin
            emit = 1'b1;
          end else if (ends_q) begin
            emit = 1'b1;
          end
        end
        if (emit) begin
          done_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (proc && emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      win_q       <= '0;
      cnt_q       <= '0;
      done_q      <= 1'b1;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      win_q       <= win_d;
      cnt_q       <= cnt_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q   <= txt_i.text_byte;
      starts_q <= txt_i.starts_text;
      ends_q   <= txt_i.ends_text;
    end
    if (proc && emit) begin
      found_q  <= hit;
      offset_q <= off;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.found        = found_q;
  assign res_o.match_offset = offset_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(cnt_q) <= CMP_W'(TEXT_MAX))
    else $error("byte count beyond text maximum");

  a_emit_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && emit) |=> done_q)
    else $error("search not closed after a result");

  a_hold_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !proc) |=> (in_valid_q && $stable(byte_q)))
    else $error("pending item lost");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (offset_q == '0))
    else $error("not-found result with nonzero offset");

endmodule
